@@ rtl/lrc_fp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_fp_pkg
// Shared types and constants for the LRC-checked frame parser.
// ----------------------------------------------------------------------------
package lrc_fp_pkg;

    localparam int MAX_DATA_LEN_DEF = 512;
    localparam int HEADER_BYTES     = 9;
    localparam int LEN_W            = 16;
    localparam int FLEN_W           = 10;
    localparam int ERR_W            = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [7:0] SOF_RESET = 8'd17;

    // register index decoded from paddr[2]
    localparam logic REG_SOF = 1'b0;

    typedef enum logic [2:0] {
        EV_TAKEN   = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_BAD     = 3'd3,
        EV_DROP    = 3'd4
    } ev_t;

    typedef struct packed {
        ev_t                 event_res;
        logic [7:0]          payload_byte;
        logic [LEN_W-1:0]    frame_cmd;
        logic [LEN_W-1:0]    frame_status;
        logic [FLEN_W-1:0]   frame_length;
        logic [ERR_W-1:0]    errors_seen;
    } res_t;

endpackage

@@ rtl/lrc_frame_parser.sv @@
// ----------------------------------------------------------------------------
// lrc_frame_parser
// Hunts for the start byte, checks the header LRCs, passes payload bytes
// through and checks the closing LRC; one result word per received byte.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_stall       rx_byte
//  output    out        out_valid / out_stall     event_res, payload_byte,
//                                                 frame_cmd, frame_status,
//                                                 frame_length, errors_seen
//  config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
//  One byte per cycle sustained while in_stall is low. The frame state is
//  updated in the cycle a word is taken; its result is registered into
//  the output register, or into the skid register behind it when that is
//  stalled. The skid holds one more, so in_stall rises only when both are
//  full; it comes straight from a flop. Reset clears the frame state, the
//  error count and sets the start byte to 17; no clearing pass is needed.
//
module lrc_frame_parser #(
    parameter int MAX_DATA_LEN = lrc_fp_pkg::MAX_DATA_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrc_fp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lrc_fp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lrc_fp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          event_res,
    output logic [7:0]                          payload_byte,
    output logic [lrc_fp_pkg::LEN_W-1:0]        frame_cmd,
    output logic [lrc_fp_pkg::LEN_W-1:0]        frame_status,
    output logic [lrc_fp_pkg::FLEN_W-1:0]       frame_length,
    output logic [lrc_fp_pkg::ERR_W-1:0]        errors_seen
);

    localparam int POS_W = $clog2(lrc_fp_pkg::HEADER_BYTES + MAX_DATA_LEN + 1);
    localparam int CMP_W = lrc_fp_pkg::LEN_W + 1;
    localparam int LEN_W = lrc_fp_pkg::LEN_W;

    localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LRC1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMD0  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CMD1  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_STS0  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_STS1  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_LEN0  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LEN1  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LRC2  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_HDR   = POS_W'(lrc_fp_pkg::HEADER_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_DATA_LEN);

    // configuration
    logic [7:0] sof_reg;
    logic       cfg_wr;

    // frame state
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [LEN_W-1:0]            cmd_reg, cmd_next;
    logic [LEN_W-1:0]            status_reg, status_next;
    logic [LEN_W-1:0]            length_reg, length_next;
    logic [lrc_fp_pkg::ERR_W-1:0] err_reg, err_next;

    // result path
    logic             in_take;
    logic             out_free;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    lrc_fp_pkg::res_t out_reg;
    lrc_fp_pkg::res_t skid_reg;
    lrc_fp_pkg::res_t res_new;

    // work signals
    logic [7:0]       sum_add;
    logic [CMP_W-1:0] frame_end;
    logic             err_inc;
    logic             is_sof;
    lrc_fp_pkg::ev_t  ev;
    logic [7:0]       pay;
    logic [lrc_fp_pkg::FLEN_W-1:0] flen;

    // ------------------------------------------------------------------
    // APB register
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lrc_fp_pkg::REG_SOF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_reg <= lrc_fp_pkg::SOF_RESET;
        end
        else if (cfg_wr)
        begin
            sof_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lrc_fp_pkg::REG_SOF)
        begin
            prdata = {{(lrc_fp_pkg::APB_DATA_W-8){1'b0}}, sof_reg};
        end
    end

    // ------------------------------------------------------------------
    // frame state update
    // ------------------------------------------------------------------
    assign sum_add   = sum_reg + rx_byte;
    assign is_sof    = (rx_byte == sof_reg);
    assign frame_end = CMP_W'(lrc_fp_pkg::HEADER_BYTES) + {1'b0, length_reg};

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        length_next = length_reg;
        err_inc     = 1'b0;
        ev          = lrc_fp_pkg::EV_TAKEN;
        pay         = 8'd0;
        flen        = '0;

        if (pos_reg == POS_HUNT)
        begin
            if (is_sof)
            begin
                pos_next = POS_LRC1;
                sum_next = rx_byte;
            end
            else
            begin
                err_inc = 1'b1;
                ev      = lrc_fp_pkg::EV_DROP;
            end
        end
        else if (pos_reg < POS_HDR)
        begin
            sum_next = sum_add;
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_CMD0 || pos_reg == POS_CMD1)
            begin
                cmd_next = {cmd_reg[7:0], rx_byte};
            end
            else if (pos_reg == POS_STS0 || pos_reg == POS_STS1)
            begin
                status_next = {status_reg[7:0], rx_byte};
            end
            else if (pos_reg == POS_LEN0 || pos_reg == POS_LEN1)
            begin
                length_next = {length_reg[7:0], rx_byte};
            end

            if ((pos_reg == POS_LRC1 || pos_reg == POS_LRC2) && sum_add != 8'd0)
            begin
                // failed check: resync if the byte is itself a start byte
                err_inc  = 1'b1;
                ev       = lrc_fp_pkg::EV_DROP;
                pos_next = is_sof ? POS_LRC1 : POS_HUNT;
                sum_next = is_sof ? rx_byte : 8'd0;
            end
            else if (pos_reg == POS_LRC2 && length_reg > LEN_LIMIT)
            begin
                err_inc  = 1'b1;
                ev       = lrc_fp_pkg::EV_DROP;
                pos_next = POS_HUNT;
                sum_next = 8'd0;
            end
        end
        else if (CMP_W'(pos_reg) < frame_end)
        begin
            sum_next = sum_add;
            pos_next = pos_reg + POS_W'(1);
            ev       = lrc_fp_pkg::EV_PAYLOAD;
            pay      = rx_byte;
        end
        else
        begin
            if (sum_add == 8'd0)
            begin
                ev   = lrc_fp_pkg::EV_GOOD;
                flen = length_reg[lrc_fp_pkg::FLEN_W-1:0];
            end
            else
            begin
                err_inc = 1'b1;
                ev      = lrc_fp_pkg::EV_BAD;
            end
            pos_next = POS_HUNT;
            sum_next = 8'd0;
        end

        err_next = err_reg + {{(lrc_fp_pkg::ERR_W-1){1'b0}}, err_inc};

        res_new.event_res    = ev;
        res_new.payload_byte = pay;
        res_new.frame_cmd    = cmd_next;
        res_new.frame_status = status_next;
        res_new.frame_length = flen;
        res_new.errors_seen  = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            sum_reg    <= 8'd0;
            cmd_reg    <= '0;
            status_reg <= '0;
            length_reg <= '0;
            err_reg    <= '0;
        end
        else if (in_take)
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            length_reg <= length_next;
            err_reg    <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid stage
    // ------------------------------------------------------------------
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // skid word goes first; input is stalled while it is held
            out_valid_reg  <= skid_valid_reg || in_take;
            skid_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_take)
            begin
                out_reg <= res_new;
            end
        end
        else if (in_take)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_reg.event_res;
    assign payload_byte = out_reg.payload_byte;
    assign frame_cmd    = out_reg.frame_cmd;
    assign frame_status = out_reg.frame_status;
    assign frame_length = out_reg.frame_length;
    assign errors_seen  = out_reg.errors_seen;

endmodule

@@ rtl/lrc_fp_checker.sv @@
// ----------------------------------------------------------------------------
// lrc_fp_checker
// Port-level checks on the frame parser's word flow, bound to the top level.
// ----------------------------------------------------------------------------
module lrc_fp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [2:0]                    event_res,
    input logic [7:0]                    payload_byte,
    input logic [lrc_fp_pkg::LEN_W-1:0]  frame_cmd,
    input logic [lrc_fp_pkg::LEN_W-1:0]  frame_status,
    input logic [lrc_fp_pkg::FLEN_W-1:0] frame_length,
    input logic [lrc_fp_pkg::ERR_W-1:0]  errors_seen
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
            && $stable(payload_byte) && $stable(frame_cmd)
            && $stable(frame_status) && $stable(frame_length)
            && $stable(errors_seen))
        else $error("result word changed while stalled");

    // input stalls only after the output was backed up
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // a word taken into an empty output shows up next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> out_valid)
        else $error("accepted word lost");

    // the held word moves up when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && out_valid && !out_stall |=> out_valid && !in_stall)
        else $error("skid word not advanced");

endmodule

bind lrc_frame_parser lrc_fp_checker u_lrc_fp_checker (.*);

@@ test/lrc_frame_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrc_frame_checker
// Watches the byte, result and register channels of the frame parser, keeps
// its own copy of the frame state, predicts one result word per byte taken
// and compares every result word field by field against the oldest
// prediction. The failure count and the number of outstanding predictions
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module lrc_frame_checker #(
    parameter int MAX_LEN = lrc_fp_pkg::MAX_DATA_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [lrc_fp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lrc_fp_pkg::APB_DATA_W-1:0]   pwdata,

    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [7:0]                          rx_byte,

    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [2:0]                          event_res,
    input  logic [7:0]                          payload_byte,
    input  logic [lrc_fp_pkg::LEN_W-1:0]        frame_cmd,
    input  logic [lrc_fp_pkg::LEN_W-1:0]        frame_status,
    input  logic [lrc_fp_pkg::FLEN_W-1:0]       frame_length,
    input  logic [lrc_fp_pkg::ERR_W-1:0]        errors_seen,

    output int                                  fail_count,
    output int                                  pending
);

    logic [7:0]                   sof_reg;
    logic [9:0]                   frame_pos;      // 0 while hunting for the start byte
    logic [7:0]                   lrc_sum;
    logic [lrc_fp_pkg::LEN_W-1:0] cmd_acc;
    logic [lrc_fp_pkg::LEN_W-1:0] status_acc;
    logic [lrc_fp_pkg::LEN_W-1:0] len_acc;
    logic [lrc_fp_pkg::ERR_W-1:0] err_total;
    lrc_fp_pkg::res_t             result_q[$];
    int                           fails;

    // Advance the frame state by one received byte and return its result word.
    function automatic lrc_fp_pkg::res_t parse_byte(input logic [7:0] b);
        lrc_fp_pkg::res_t r;
        int unsigned      at;
        at             = 32'(frame_pos);
        r.event_res    = lrc_fp_pkg::EV_TAKEN;
        r.payload_byte = '0;
        r.frame_length = '0;
        if (at == 0)
        begin
            if (b == sof_reg)
            begin
                frame_pos = 10'd1;
                lrc_sum   = b;
            end
            else
            begin
                err_total   = err_total + 1'b1;
                r.event_res = lrc_fp_pkg::EV_DROP;
            end
        end
        else if (at < lrc_fp_pkg::HEADER_BYTES)
        begin
            lrc_sum = lrc_sum + b;
            case (at) inside
                2, 3:    cmd_acc    = {cmd_acc[7:0], b};
                4, 5:    status_acc = {status_acc[7:0], b};
                6, 7:    len_acc    = {len_acc[7:0], b};
                default: ;
            endcase
            frame_pos = 10'(at + 1);
            if ((at == 1 || at == lrc_fp_pkg::HEADER_BYTES - 1) && lrc_sum != 8'h00)
            begin
                // failed header check; a start byte here opens a new frame
                err_total   = err_total + 1'b1;
                r.event_res = lrc_fp_pkg::EV_DROP;
                frame_pos   = '0;
                lrc_sum     = '0;
                if (b == sof_reg)
                begin
                    frame_pos = 10'd1;
                    lrc_sum   = b;
                end
            end
            else if (at == lrc_fp_pkg::HEADER_BYTES - 1 && len_acc > MAX_LEN)
            begin
                err_total   = err_total + 1'b1;
                r.event_res = lrc_fp_pkg::EV_DROP;
                frame_pos   = '0;
                lrc_sum     = '0;
            end
        end
        else if (at < lrc_fp_pkg::HEADER_BYTES + len_acc)
        begin
            lrc_sum        = lrc_sum + b;
            frame_pos      = 10'(at + 1);
            r.event_res    = lrc_fp_pkg::EV_PAYLOAD;
            r.payload_byte = b;
        end
        else
        begin
            if (8'(lrc_sum + b) == 8'h00)
            begin
                r.event_res    = lrc_fp_pkg::EV_GOOD;
                r.frame_length = len_acc[lrc_fp_pkg::FLEN_W-1:0];
            end
            else
            begin
                err_total   = err_total + 1'b1;
                r.event_res = lrc_fp_pkg::EV_BAD;
            end
            frame_pos = '0;
            lrc_sum   = '0;
        end
        r.frame_cmd    = cmd_acc;
        r.frame_status = status_acc;
        r.errors_seen  = err_total;
        return r;
    endfunction

    function automatic int check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lrc_fp_pkg::res_t want;
        int               bad;
        if (!rst_n)
        begin
            sof_reg    = lrc_fp_pkg::SOF_RESET;
            frame_pos  = '0;
            lrc_sum    = '0;
            cmd_acc    = '0;
            status_acc = '0;
            len_acc    = '0;
            err_total  = '0;
            fails      = 0;
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // check the result word first so a word arriving with none
            // outstanding is not hidden by a byte taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual event %0d",
                             $time, event_res);
                    fails++;
                end
                else
                begin
                    want = result_q.pop_front();
                    bad  = 0;
                    bad += check_field("event_res", 32'(want.event_res), 32'(event_res));
                    bad += check_field("payload_byte", 32'(want.payload_byte),
                                       32'(payload_byte));
                    bad += check_field("frame_cmd", 32'(want.frame_cmd), 32'(frame_cmd));
                    bad += check_field("frame_status", 32'(want.frame_status),
                                       32'(frame_status));
                    bad += check_field("frame_length", 32'(want.frame_length),
                                       32'(frame_length));
                    bad += check_field("errors_seen", want.errors_seen, errors_seen);
                    fails += bad;
                end
            end
            if (psel && penable && pwrite && pready
                && paddr[lrc_fp_pkg::APB_ADDR_W-1:2] == lrc_fp_pkg::REG_SOF)
                sof_reg = pwdata[7:0];
            if (in_valid && !in_stall)
                result_q.push_back(parse_byte(rx_byte));
            fail_count <= fails;
            pending    <= result_q.size();
        end
    end

endmodule

@@ test/tb_lrc_frame_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lrc_frame_parser
// Drives framed byte streams into the frame parser: good frames, header and
// trailer check failures, resync on a start byte, oversize lengths, cut
// frames and line noise, under several start byte settings, with random
// gaps and back-pressure. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_lrc_frame_parser;

    localparam int STALL_LIMIT = 2000;
    localparam int QUOTA       = 110;
    localparam logic [lrc_fp_pkg::APB_ADDR_W-1:0] SOF_ADDR    = {lrc_fp_pkg::REG_SOF, 2'b00};
    // no register lives at index 1; writes there must change nothing
    localparam logic [lrc_fp_pkg::APB_ADDR_W-1:0] UNUSED_ADDR = {~lrc_fp_pkg::REG_SOF, 2'b00};

    typedef enum int {
        FLAW_NONE,
        FLAW_LRC1,
        FLAW_LRC1_SOF,
        FLAW_LRC2,
        FLAW_LRC2_SOF,
        FLAW_LONG,
        FLAW_FINAL,
        FLAW_CUT
    } flaw_t;

    logic                                clk      = 1'b0;
    logic                                rst_n    = 1'b0;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [lrc_fp_pkg::APB_ADDR_W-1:0]   paddr    = '0;
    logic [lrc_fp_pkg::APB_DATA_W-1:0]   pwdata   = '0;
    logic [lrc_fp_pkg::APB_DATA_W-1:0]   prdata;
    logic                                pready;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [7:0]                          rx_byte  = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [2:0]                          event_res;
    logic [7:0]                          payload_byte;
    logic [lrc_fp_pkg::LEN_W-1:0]        frame_cmd;
    logic [lrc_fp_pkg::LEN_W-1:0]        frame_status;
    logic [lrc_fp_pkg::FLEN_W-1:0]       frame_length;
    logic [lrc_fp_pkg::ERR_W-1:0]        errors_seen;

    int                                  fail_count;
    int                                  pending;
    int                                  bytes_sent  = 0;
    int                                  quiet_count = 0;
    logic                                gaps_on     = 1'b1;
    logic [7:0]                          sof_now     = lrc_fp_pkg::SOF_RESET;

    lrc_frame_parser uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .payload_byte (payload_byte),
        .frame_cmd    (frame_cmd),
        .frame_status (frame_status),
        .frame_length (frame_length),
        .errors_seen  (errors_seen)
    );

    lrc_frame_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .payload_byte (payload_byte),
        .frame_cmd    (frame_cmd),
        .frame_status (frame_status),
        .frame_length (frame_length),
        .errors_seen  (errors_seen),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= gaps_on && ($urandom_range(99) < 11);

    // watchdog: end the run if no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count <= 0;
        else if (quiet_count >= STALL_LIMIT)
        begin
            $display("lrc_frame_parser verification failed");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    function automatic logic [7:0] lrc_of(input logic [7:0] sum);
        return 8'(9'h100 - sum);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // hold the sender until every result word is back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic reg_write(input logic [lrc_fp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (addr == SOF_ADDR)
            sof_now = data[7:0];
    endtask

    task automatic send_frame(input logic [15:0] cmd, input logic [15:0] stat,
                              input logic [15:0] len, input flaw_t flaw);
        logic [7:0] hdr [lrc_fp_pkg::HEADER_BYTES];
        logic [7:0] sum;
        logic [7:0] b;
        int         fault_at;
        int         first;
        int         n_pay;
        hdr[0] = sof_now;
        hdr[1] = lrc_of(sof_now);
        hdr[2] = cmd[15:8];
        hdr[3] = cmd[7:0];
        hdr[4] = stat[15:8];
        hdr[5] = stat[7:0];
        hdr[6] = len[15:8];
        hdr[7] = len[7:0];
        sum = '0;
        for (int i = 0; i < lrc_fp_pkg::HEADER_BYTES - 1; i++)
            sum = sum + hdr[i];
        hdr[8] = lrc_of(sum);
        sum    = '0;
        first  = 0;

        fault_at = (flaw == FLAW_LRC1 || flaw == FLAW_LRC1_SOF) ? 1 :
                   (flaw == FLAW_LRC2 || flaw == FLAW_LRC2_SOF) ?
                   lrc_fp_pkg::HEADER_BYTES - 1 : 0;
        if (flaw == FLAW_LRC1 || flaw == FLAW_LRC2)
        begin
            for (int i = 0; i < fault_at; i++)
                send_byte(hdr[i]);
            send_byte(hdr[fault_at] ^ 8'($urandom_range(1, 255)));
            return;
        end
        if ((flaw == FLAW_LRC1_SOF || flaw == FLAW_LRC2_SOF) && hdr[fault_at] != sof_now)
        begin
            // the failing check byte is a start byte: resync and finish
            // the frame from its second byte
            for (int i = 0; i < fault_at; i++)
                send_byte(hdr[i]);
            send_byte(sof_now);
            first = 1;
        end

        for (int i = first; i < lrc_fp_pkg::HEADER_BYTES; i++)
            send_byte(hdr[i]);
        if (flaw == FLAW_LONG)
            return;

        n_pay = (flaw == FLAW_CUT) ? $urandom_range(0, len) : len;
        for (int i = 0; i < n_pay; i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        if (flaw == FLAW_CUT)
            return;
        b = lrc_of(sum);
        if (flaw == FLAW_FINAL)
            b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
    endtask

    task automatic random_traffic(input int quota, input logic with_max_frame);
        int          start;
        int          pick;
        flaw_t       flaw;
        logic [15:0] len;
        start = bytes_sent;
        while (bytes_sent - start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_byte(($urandom_range(3) == 0) ? sof_now : 8'($urandom));
            else
            begin
                pick = $urandom_range(99);
                if (pick < 55)      flaw = FLAW_NONE;
                else if (pick < 62) flaw = FLAW_LRC1;
                else if (pick < 69) flaw = FLAW_LRC1_SOF;
                else if (pick < 76) flaw = FLAW_LRC2;
                else if (pick < 83) flaw = FLAW_LRC2_SOF;
                else if (pick < 88) flaw = FLAW_LONG;
                else if (pick < 94) flaw = FLAW_FINAL;
                else                flaw = FLAW_CUT;
                if (flaw == FLAW_LONG)
                    len = 16'($urandom_range(lrc_fp_pkg::MAX_DATA_LEN_DEF + 1, 65535));
                else
                    len = 16'($urandom_range(0, 12));
                send_frame(16'($urandom), 16'($urandom), len, flaw);
            end
        end
        if (with_max_frame)
            send_frame(16'($urandom), 16'($urandom), 16'(lrc_fp_pkg::MAX_DATA_LEN_DEF),
                       FLAW_NONE);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: junk at both extremes, a zero-length frame, and a
        // header check failing on a start byte followed by the resynced frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'hFFFF, 16'h0000, 16'd0, FLAW_NONE);
        send_frame(16'h0000, 16'hFFFF, 16'd0, FLAW_LRC1_SOF);
        random_traffic(QUOTA, 1'b0);

        drain();
        reg_write(UNUSED_ADDR, 32'h0000_0055);
        reg_write(SOF_ADDR, 32'h0000_0000);
        random_traffic(QUOTA, 1'b0);

        // long stretch with no gaps on either side
        drain();
        reg_write(SOF_ADDR, 32'h0000_00FF);
        gaps_on <= 1'b0;
        random_traffic(QUOTA, 1'b1);

        drain();
        gaps_on <= 1'b1;
        reg_write(SOF_ADDR, 32'h0000_0080);
        random_traffic(QUOTA, 1'b0);

        drain();
        reg_write(SOF_ADDR, 32'($urandom_range(1, 254)));
        random_traffic(QUOTA, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("lrc_frame_parser verification clean");
        else
            $display("lrc_frame_parser verification failed");
        $finish;
    end

endmodule
